/* hdl/ipv4_dotted_address_parser_macros.svh */
// assertion macros for the ipv4 dotted address parser
`ifndef IPV4_DOTTED_ADDRESS_PARSER_MACROS_SVH
`define IPV4_DOTTED_ADDRESS_PARSER_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define IPV4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ipv4 parser check failed");
// checked at every edge, reset included
`define IPV4_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ipv4 parser reset check failed");
`else
`define IPV4_ASSERT(lbl, prop)
`define IPV4_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* hdl/ipv4_pkg.sv */
// shared types, constants and the address assembly function
`default_nettype none

package ipv4_pkg;

  localparam int CHAR_W = 8;
  localparam int ADDR_W = 32;
  localparam int PART_W = 8;
  localparam int NUM_SAVED = 3;

  localparam logic [ADDR_W-1:0] LIM_ONE   = 32'h00ff_ffff;
  localparam logic [ADDR_W-1:0] LIM_TWO   = 32'h0000_ffff;
  localparam logic [ADDR_W-1:0] LIM_THREE = 32'h0000_00ff;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] value;
  } fin_t;

  // range checks per form and merge of the saved parts
  function automatic fin_t finish_addr(input logic [ADDR_W-1:0] acc,
                                       input logic [1:0]        cnt,
                                       input logic              over,
                                       input logic [PART_W-1:0] p0,
                                       input logic [PART_W-1:0] p1,
                                       input logic [PART_W-1:0] p2);
    fin_t f;
    f.ok    = !over;
    f.value = acc;
    unique case (cnt)
      2'd0: begin
        f.value = acc;
      end
      2'd1: begin
        if (acc > LIM_ONE) f.ok = 1'b0;
        f.value = {p0, acc[23:0]};
      end
      2'd2: begin
        if (acc > LIM_TWO) f.ok = 1'b0;
        f.value = {p0, p1, acc[15:0]};
      end
      2'd3: begin
        if (acc > LIM_THREE) f.ok = 1'b0;
        f.value = {p0, p1, p2, acc[7:0]};
      end
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* hdl/ipv4_if.sv */
// valid/ready channel interfaces for characters in and addresses out
`default_nettype none

interface ipv4_in_if;
  import ipv4_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface ipv4_out_if;
  import ipv4_pkg::*;
  logic              valid;
  logic              ready;
  logic              parse_ok;
  logic [ADDR_W-1:0] address_value;

  modport source (output valid, output parse_ok, output address_value, input ready);
  modport sink   (input valid, input parse_ok, input address_value, output ready);
endinterface

`default_nettype wire

/* hdl/ipv4_dotted_address_parser.sv */
// top level: inet_aton style ipv4 address parser, one character per beat
//
// in_ch carries the address text one byte per beat, end_of_string set on the
// final byte of each string. out_ch gives one beat per string: parse_ok and
// the 32-bit address, first part in the top byte, zero on any error.
// a byte is taken into an input register, then a single pass of logic
// (digit scale and add, or range check and part merge) updates the parse
// state and, for the final byte, loads the output register.
// throughput: one byte per cycle, bounded by the accumulate step, unless a final byte waits on out_ch.
// bytes that are not final never wait on out_ch; a final byte waits in the
// input register only while an earlier result is still unclaimed, and
// in_ch.ready drops only then.
// after the final byte the parse state returns to its reset values.
// reset (rst_n low, synchronous) empties both registers and clears the
// parse state; a string in flight is dropped.
`default_nettype none
`include "ipv4_dotted_address_parser_macros.svh"

module ipv4_dotted_address_parser (
  input  logic          clk,
  input  logic          rst_n,
  ipv4_in_if.sink       in_ch,
  ipv4_out_if.source    out_ch
);
  import ipv4_pkg::*;

  // input register
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_last_r;

  // parse state
  phase_t            phase_r;
  logic [ADDR_W-1:0] acc_r;
  base_t             base_r;
  logic [PART_W-1:0] part_r [NUM_SAVED];
  logic [1:0]        count_r;
  logic              over_r;   // some saved part exceeded one byte

  // output register
  logic              out_valid_r;
  logic              out_ok_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic s1_adv;
  logic in_ready;

  // next state from the byte in the input register
  phase_t            phase_nxt;
  logic [ADDR_W-1:0] acc_nxt;
  base_t             base_nxt;
  logic [1:0]        count_nxt;
  logic              over_nxt;
  logic              wr_part;
  logic              fin_req;
  logic              in_part;
  logic              fin_go;
  fin_t              fin;
  logic              res_ok;
  logic [ADDR_W-1:0] res_addr;

  // character classes
  logic              is_dig;
  logic              is_ws;
  logic              is_hex_lo;
  logic              is_hex_up;
  logic [3:0]        dig_val;
  logic [3:0]        hex_val;
  logic [ADDR_W-1:0] acc_scaled;

  // a final byte needs the output register free, others pass straight on
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_ch.ready = in_ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.parse_ok      = out_ok_r;
  assign out_ch.address_value = out_addr_r;

  assign is_dig    = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign is_hex_lo = (s1_char_r >= CH_LA) && (s1_char_r <= CH_LF);
  assign is_hex_up = (s1_char_r >= CH_UA) && (s1_char_r <= CH_UF);
  assign is_ws     = (s1_char_r == CH_NUL) || (s1_char_r == CH_SPACE) ||
                     ((s1_char_r >= CH_TAB) && (s1_char_r <= CH_CR));
  assign dig_val   = s1_char_r[3:0];
  // 'a' and 'A' both end in 1, so add 9 to get 10
  assign hex_val   = s1_char_r[3:0] + 4'd9;

  // multiply by the base with shifts, times ten as times eight plus times two
  always_comb begin
    unique case (base_r)
      BASE_OCT: acc_scaled = {acc_r[ADDR_W-4:0], 3'b000};
      BASE_HEX: acc_scaled = {acc_r[ADDR_W-5:0], 4'b0000};
      default:  acc_scaled = {acc_r[ADDR_W-4:0], 3'b000} + {acc_r[ADDR_W-2:0], 1'b0};
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    count_nxt = count_r;
    over_nxt  = over_r;
    wr_part   = 1'b0;
    fin_req   = 1'b0;
    in_part   = 1'b0;

    unique case (phase_r)
      PH_START: begin
        if (!is_dig) begin
          phase_nxt = PH_ERROR;
        end else if (s1_char_r == CH_ZERO) begin
          acc_nxt   = '0;
          base_nxt  = BASE_OCT;
          phase_nxt = PH_ZERO;
        end else begin
          acc_nxt   = {{(ADDR_W-4){1'b0}}, dig_val};
          base_nxt  = BASE_DEC;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_ZERO: begin
        if ((s1_char_r == CH_LX) || (s1_char_r == CH_UX)) begin
          base_nxt  = BASE_HEX;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_DIGITS;
          in_part   = 1'b1;
        end
      end
      PH_DIGITS: begin
        in_part = 1'b1;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    // a byte inside a part: digit, dot, terminator or error
    if (in_part) begin
      priority if (is_dig) begin
        acc_nxt = acc_scaled + {{(ADDR_W-4){1'b0}}, dig_val};
      end else if ((base_r == BASE_HEX) && (is_hex_lo || is_hex_up)) begin
        acc_nxt = {acc_r[ADDR_W-5:0], hex_val};
      end else if (s1_char_r == CH_DOT) begin
        if (count_r == 2'd3) begin
          phase_nxt = PH_ERROR;
        end else begin
          wr_part   = 1'b1;
          count_nxt = count_r + 2'd1;
          over_nxt  = over_r || (acc_r > LIM_THREE);
          acc_nxt   = '0;
          base_nxt  = BASE_DEC;
          phase_nxt = PH_START;
        end
      end else if (is_ws) begin
        fin_req = 1'b1;
      end else begin
        phase_nxt = PH_ERROR;
      end
    end

    // one shared finish: on a terminator, or on the final byte inside a part
    fin_go = fin_req ||
             (s1_last_r && ((phase_nxt == PH_ZERO) || (phase_nxt == PH_DIGITS)));
    fin = finish_addr(acc_nxt, count_nxt, over_nxt, part_r[0], part_r[1], part_r[2]);
    if (fin_go) begin
      if (fin.ok) begin
        acc_nxt   = fin.value;
        phase_nxt = PH_DONE;
      end else begin
        acc_nxt   = '0;
        phase_nxt = PH_ERROR;
      end
    end

    res_ok   = (phase_nxt == PH_DONE);
    res_addr = res_ok ? acc_nxt : '0;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_ch.valid && in_ready) begin
      s1_char_r <= in_ch.char_code;
      s1_last_r <= in_ch.end_of_string;
    end
  end

  // parse state, back to reset values after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      base_r  <= BASE_DEC;
      count_r <= 2'd0;
      over_r  <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        phase_r <= PH_START;
        acc_r   <= '0;
        base_r  <= BASE_DEC;
        count_r <= 2'd0;
        over_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        base_r  <= base_nxt;
        count_r <= count_nxt;
        over_r  <= over_nxt;
      end
    end
  end

  // saved parts keep their low byte only, the overflow flag covers the rest
  always_ff @(posedge clk) begin
    if (s1_adv && !s1_last_r && wr_part) begin
      part_r[count_r] <= acc_r[PART_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      out_ok_r   <= res_ok;
      out_addr_r <= res_addr;
    end
  end

  // checks
  `IPV4_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (phase_r == PH_START) && (count_r == 2'd0))
  `IPV4_ASSERT(a_bad_is_zero, out_valid_r && !out_ok_r |-> out_addr_r == '0)
  `IPV4_ASSERT(a_final_restarts, s1_adv && s1_last_r |=> (phase_r == PH_START) && (acc_r == '0))
  `IPV4_ASSERT(a_result_from_final, $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the ipv4 dotted address parser
`timescale 1ns / 1ps

module tb;
  import ipv4_pkg::*;

  // one byte of address text as it waits to be driven
  typedef struct {
    logic [CHAR_W-1:0] code;
    bit                last;
    bit                drain_first;  // hold this beat until all addresses are back
  } char_beat_t;

  // one parsed address as the block should deliver it
  typedef struct {
    logic              ok;
    logic [ADDR_W-1:0] value;
  } address_result_t;

  // receiver stall patterns, switched every so often
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_QUARTER,
    RX_STARVE
  } stall_mode_t;

  logic clk;
  logic rst_n;

  ipv4_in_if  in_ch ();
  ipv4_out_if out_ch ();

  ipv4_dotted_address_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // shadow parser: its own copy of the parse state, updated per beat
  // ---------------------------------------------------------------------
  phase_t            parse_ph;
  base_t             num_base;
  logic [ADDR_W-1:0] part_acc;
  logic [ADDR_W-1:0] saved_part [NUM_SAVED];
  int unsigned       saved_cnt;

  function automatic bit is_digit(input logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // nul or c whitespace ends the text
  function automatic bit is_terminator(input logic [CHAR_W-1:0] c);
    return c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_parser();
    parse_ph  = PH_START;
    num_base  = BASE_DEC;
    part_acc  = '0;
    saved_cnt = 0;
    for (int i = 0; i < NUM_SAVED; i++) saved_part[i] = '0;
  endfunction

  // close the last part: per-form range checks, then merge saved parts on top
  function automatic void close_address();
    logic [ADDR_W-1:0] v;
    bit                good;
    v    = part_acc;
    good = 1'b1;
    for (int i = 0; i < saved_cnt; i++)
      if (saved_part[i] > LIM_THREE) good = 1'b0;
    case (saved_cnt)
      1: begin
        if (v > LIM_ONE) good = 1'b0;
        v = v | (saved_part[0] << 24);
      end
      2: begin
        if (v > LIM_TWO) good = 1'b0;
        v = v | (saved_part[0] << 24) | (saved_part[1] << 16);
      end
      3: begin
        if (v > LIM_THREE) good = 1'b0;
        v = v | (saved_part[0] << 24) | (saved_part[1] << 16) | (saved_part[2] << 8);
      end
      default: ;
    endcase
    if (good) begin
      part_acc = v;
      parse_ph = PH_DONE;
    end else begin
      part_acc = '0;
      parse_ph = PH_ERROR;
    end
  endfunction

  // a byte inside a part whose base is already known
  function automatic void take_part_char(input logic [CHAR_W-1:0] c);
    logic [ADDR_W-1:0] scale;
    if (is_digit(c)) begin
      // octal parts take 8 and 9 too, as value*8+digit
      scale    = (num_base == BASE_HEX) ? 16 : ((num_base == BASE_OCT) ? 8 : 10);
      part_acc = part_acc * scale + (c - CH_ZERO);
    end else if (num_base == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
      part_acc = (part_acc << 4) | (c - CH_LA + 10);
    end else if (num_base == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
      part_acc = (part_acc << 4) | (c - CH_UA + 10);
    end else if (c == CH_DOT) begin
      if (saved_cnt >= NUM_SAVED) begin
        parse_ph = PH_ERROR;  // a fourth dot
      end else begin
        saved_part[saved_cnt] = part_acc;
        saved_cnt++;
        part_acc = '0;
        num_base = BASE_DEC;
        parse_ph = PH_START;
      end
    end else if (is_terminator(c)) begin
      close_address();
    end else begin
      parse_ph = PH_ERROR;
    end
  endfunction

  // advance the shadow parser by one beat; 1 when the beat yields an address
  function automatic bit address_step(input logic [CHAR_W-1:0] c, input bit last,
                                      output address_result_t res);
    res.ok    = 1'b0;
    res.value = '0;
    case (parse_ph)
      PH_START: begin
        // empty part or a non-digit where a part begins
        if (!is_digit(c)) begin
          parse_ph = PH_ERROR;
        end else if (c == CH_ZERO) begin
          part_acc = '0;
          num_base = BASE_OCT;
          parse_ph = PH_ZERO;
        end else begin
          part_acc = c - CH_ZERO;
          num_base = BASE_DEC;
          parse_ph = PH_DIGITS;
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          num_base = BASE_HEX;  // bare 0x leaves the part at zero
          parse_ph = PH_DIGITS;
        end else begin
          parse_ph = PH_DIGITS;
          take_part_char(c);
        end
      end
      PH_DIGITS: begin
        take_part_char(c);
      end
      PH_DONE: ;  // bytes after a terminator are ignored
      default: begin
        parse_ph = PH_ERROR;
      end
    endcase
    if (!last) return 1'b0;
    // final byte without a terminator ends the open part
    if (parse_ph == PH_ZERO || parse_ph == PH_DIGITS) close_address();
    if (parse_ph == PH_DONE) begin
      res.ok    = 1'b1;
      res.value = part_acc;
    end
    clear_parser();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // address text generation
  // ---------------------------------------------------------------------
  char_beat_t        pending_beats [$];
  address_result_t   expected_addrs [$];
  logic [CHAR_W-1:0] str_bytes [$];
  int                beats_queued;

  // hand the current text to the driver, final byte marked
  task automatic queue_string(input bit drain);
    char_beat_t b;
    for (int i = 0; i < str_bytes.size(); i++) begin
      b.code        = str_bytes[i];
      b.last        = (i == str_bytes.size() - 1);
      b.drain_first = drain && (i == 0);
      pending_beats.push_back(b);
    end
    beats_queued += str_bytes.size();
  endtask

  task automatic queue_text(input string s);
    str_bytes = {};
    for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
    queue_string(1'b0);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int d, input bit upper);
    if (d < 10) return CH_ZERO + CHAR_W'(d);
    return (upper ? CH_UA : CH_LA) + CHAR_W'(d - 10);
  endfunction

  // one part in a random notation; now and then a long decimal digit run that can wrap 32 bits
  task automatic append_part(input logic [ADDR_W-1:0] v);
    logic [CHAR_W-1:0] digits [$];
    int                radix;
    int                style;
    bit                upper;
    style = $urandom_range(0, 99);
    upper = 1'($urandom_range(0, 1));
    if (style < 4) begin
      str_bytes.push_back(digit_char($urandom_range(1, 9), 1'b0));
      repeat ($urandom_range(9, 12)) str_bytes.push_back(digit_char($urandom_range(0, 9), 1'b0));
      return;
    end
    radix = (style < 50) ? 10 : ((style < 70) ? 8 : 16);
    if (radix == 8) begin
      str_bytes.push_back(CH_ZERO);
      if ($urandom_range(0, 3) == 0) str_bytes.push_back(CH_ZERO);
    end else if (radix == 16) begin
      str_bytes.push_back(CH_ZERO);
      str_bytes.push_back($urandom_range(0, 1) ? CH_UX : CH_LX);
      if (v == 0 && $urandom_range(0, 1)) return;  // bare prefix
    end
    if (v == 0 && radix != 8) str_bytes.push_back(CH_ZERO);
    while (v != 0) begin
      digits.push_front(digit_char(v % radix, upper));
      v = v / radix;
    end
    foreach (digits[i]) str_bytes.push_back(digits[i]);
  endtask

  function automatic logic [ADDR_W-1:0] pick_part(input bit is_last, input int n_saved);
    logic [ADDR_W-1:0] lim;
    int                r;
    r = $urandom_range(0, 99);
    if (!is_last) begin
      if (r < 5) return $urandom_range(256, 4095);
      if (r < 12) return 0;
      if (r < 19) return LIM_THREE;
      return $urandom_range(0, 255);
    end
    case (n_saved)
      0:       lim = '1;
      1:       lim = LIM_ONE;
      2:       lim = LIM_TWO;
      default: lim = LIM_THREE;
    endcase
    if (r < 10) return lim;
    if (r < 17) return lim + 1;
    if (r < 22) return 0;
    if (r < 40) return $urandom_range(0, 255);
    return $urandom_range(0, lim);
  endfunction

  // an a / a.b / a.b.c / a.b.c.d, parts sometimes out of range, maybe terminated and followed by junk
  task automatic build_address();
    int nparts;
    nparts    = $urandom_range(1, 4);
    str_bytes = {};
    for (int i = 0; i < nparts; i++) begin
      if (i > 0) str_bytes.push_back(CH_DOT);
      append_part(pick_part(i == nparts - 1, nparts - 1));
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 2))
        0:       str_bytes.push_back(CH_NUL);
        1:       str_bytes.push_back(CH_SPACE);
        default: str_bytes.push_back(CHAR_W'($urandom_range(CH_TAB, CH_CR)));
      endcase
      repeat ($urandom_range(0, 4)) str_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: bursts of beats with random gaps, predicts each accepted beat
  // ---------------------------------------------------------------------
  int              burst_left;
  int              gap_left;
  char_beat_t      next_beat;
  address_result_t predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.char_code     <= '0;
      in_ch.end_of_string <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (address_step(in_ch.char_code, in_ch.end_of_string, predicted))
          expected_addrs.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (pending_beats.size() == 0 ||
                     (pending_beats[0].drain_first && expected_addrs.size() != 0)) begin
          // nothing left, or holding off until every address is back
          in_ch.valid <= 1'b0;
        end else begin
          next_beat           = pending_beats.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.char_code     <= next_beat.code;
          in_ch.end_of_string <= next_beat.last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: stalls on its own pattern, checks each address beat in order
  // ---------------------------------------------------------------------
  int              mismatches;
  int              rx_cycle;
  stall_mode_t     rx_mode;
  address_result_t oldest;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_addrs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: address beat with none pending: ok=%0b value=%h",
                     $realtime, out_ch.parse_ok, out_ch.address_value);
        end else begin
          oldest = expected_addrs.pop_front();
          if (out_ch.parse_ok !== oldest.ok || out_ch.address_value !== oldest.value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: address mismatch: ok exp %0b got %0b, value exp %h got %h",
                       $realtime, oldest.ok, out_ch.parse_ok, oldest.value,
                       out_ch.address_value);
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 150 == 0) rx_mode = stall_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS:  out_ch.ready <= 1'b1;
        RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
        RX_QUARTER: out_ch.ready <= (rx_cycle % 4 == 0);
        default:    out_ch.ready <= (rx_cycle % 23 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int idx;
    int kind;
    int pos;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.char_code     = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
    burst_left          = 1;
    gap_left            = 0;
    rx_mode             = RX_ALWAYS;
    clear_parser();

    // directed strings
    queue_text("0");                 // lone zero
    str_bytes = {CH_NUL};            // empty text
    queue_string(1'b0);
    str_bytes = {8'hff};             // high byte is neither digit nor space
    queue_string(1'b0);
    queue_text("0X");                // bare hex prefix
    queue_text("09");                // 9 inside an octal part
    queue_text("1.2.");              // dot followed by the end
    queue_text("1.2.3.4.");          // fourth dot
    queue_text("256.1");             // leading part out of range
    str_bytes = {CH_ZERO + 8'd7, CH_TAB, 8'h7a};
    queue_string(1'b0);              // terminator then junk

    // random strings: mostly well formed, some broken, some noise
    idx = 0;
    while (beats_queued < 780) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_address();
      end else if (kind < 85) begin
        build_address();
        pos = $urandom_range(0, str_bytes.size() - 1);
        case ($urandom_range(0, 2))
          0: str_bytes[pos] = CHAR_W'($urandom_range(0, 255));
          1: str_bytes.insert(pos, CH_DOT);
          default: if (str_bytes.size() > 1) str_bytes.delete(pos);
        endcase
      end else begin
        str_bytes = {};
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1))
            str_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
          else
            str_bytes.push_back($urandom_range(0, 1) ? CH_DOT :
                                CHAR_W'($urandom_range(CH_ZERO, CH_NINE)));
        end
      end
      // every so often the sender waits for the receiver to catch up fully
      queue_string(idx % 37 == 3);
      idx++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all beats out, then all addresses back, then a little settling time
    do @(posedge clk); while (pending_beats.size() != 0 || in_ch.valid);
    do @(posedge clk); while (expected_addrs.size() != 0);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_addrs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/ipv4_pkg.sv
hdl/ipv4_if.sv
hdl/ipv4_dotted_address_parser.sv
tb/tb.sv
